// ===== design/segment_triangle_intersect_defines.svh =====
// assertion macros shared by the segment/triangle intersection design
// depends on nothing; included by modules that carry assertions
`ifndef SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH
`define SEGMENT_TRIANGLE_INTERSECT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define STI_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication outside reset
`define STI_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ===== design/sti_pkg.sv =====
// types, widths and miss codes for the segment/triangle intersection pipeline
// depends on nothing
package sti_pkg;
	localparam int COORD_WIDTH = 20;
	localparam int POINT_WIDTH = 60;
	localparam int DIFF_WIDTH = COORD_WIDTH + 1;
	localparam int CROSS_WIDTH = 2 * DIFF_WIDTH + 1;
	localparam int DOT_WIDTH = CROSS_WIDTH + DIFF_WIDTH + 2;
	localparam int SUM_WIDTH = DOT_WIDTH + 1;

	typedef enum logic [2:0] {
		CAUSE_HIT = 3'd0,
		CAUSE_DEGENERATE = 3'd1,
		CAUSE_PARALLEL = 3'd2,
		CAUSE_BEYOND = 3'd3,
		CAUSE_SINGULAR = 3'd4,
		CAUSE_OUTSIDE = 3'd5
	} cause_t;

	typedef logic signed [DIFF_WIDTH-1:0] diff_t;
	typedef logic signed [CROSS_WIDTH-1:0] cross_t;
	typedef logic signed [DOT_WIDTH-1:0] dot_t;

	typedef struct packed {
		diff_t x;
		diff_t y;
		diff_t z;
	} dvec_t;

	typedef struct packed {
		cross_t x;
		cross_t y;
		cross_t z;
	} cvec_t;

	function automatic logic signed [COORD_WIDTH:0] coord(input logic [POINT_WIDTH-1:0] w,
		input int slot);
		logic [COORD_WIDTH-1:0] f;
		f = COORD_WIDTH'(w >> (slot * COORD_WIDTH));
		return {f[COORD_WIDTH-1], f};
	endfunction

	function automatic dvec_t vdiff(input logic [POINT_WIDTH-1:0] p,
		input logic [POINT_WIDTH-1:0] q);
		dvec_t o;
		o.x = diff_t'(coord(p, 2) - coord(q, 2));
		o.y = diff_t'(coord(p, 1) - coord(q, 1));
		o.z = diff_t'(coord(p, 0) - coord(q, 0));
		return o;
	endfunction

	function automatic cvec_t vcross(input dvec_t a, input dvec_t b);
		cvec_t o;
		o.x = cross_t'(a.y) * cross_t'(b.z) - cross_t'(a.z) * cross_t'(b.y);
		o.y = cross_t'(a.z) * cross_t'(b.x) - cross_t'(a.x) * cross_t'(b.z);
		o.z = cross_t'(a.x) * cross_t'(b.y) - cross_t'(a.y) * cross_t'(b.x);
		return o;
	endfunction

	function automatic dot_t vdot(input cvec_t c, input dvec_t d);
		return dot_t'(c.x) * dot_t'(d.x) + dot_t'(c.y) * dot_t'(d.y)
			+ dot_t'(c.z) * dot_t'(d.z);
	endfunction
endpackage

// ===== design/sti_stage_cross.sv =====
// stages 1 and 2: edge vectors, then normal and the two cross products
// depends on sti_pkg
module sti_stage_cross (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  logic [sti_pkg::POINT_WIDTH-1:0] seg_origin,
	input  logic [sti_pkg::POINT_WIDTH-1:0] seg_end,
	input  logic [sti_pkg::POINT_WIDTH-1:0] corner_a,
	input  logic [sti_pkg::POINT_WIDTH-1:0] corner_b,
	input  logic [sti_pkg::POINT_WIDTH-1:0] corner_c,
	output logic valid_s2,
	output sti_pkg::cvec_t n_s2,
	output sti_pkg::cvec_t vxd_s2,
	output sti_pkg::cvec_t wxd_s2,
	output sti_pkg::dvec_t u_s2,
	output sti_pkg::dvec_t d_s2,
	output sti_pkg::dvec_t w0_s2
);
	logic valid_s1;
	sti_pkg::dvec_t u_s1, v_s1, d_s1, w0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1 <= sti_pkg::vdiff(corner_b, corner_a);
			v_s1 <= sti_pkg::vdiff(corner_c, corner_a);
			d_s1 <= sti_pkg::vdiff(seg_end, seg_origin);
			w0_s1 <= sti_pkg::vdiff(seg_origin, corner_a);
			n_s2 <= sti_pkg::vcross(u_s1, v_s1);
			vxd_s2 <= sti_pkg::vcross(v_s1, d_s1);
			wxd_s2 <= sti_pkg::vcross(w0_s1, d_s1);
			u_s2 <= u_s1;
			d_s2 <= d_s1;
			w0_s2 <= w0_s1;
		end
	end
endmodule

// ===== design/sti_stage_test.sv =====
// stages 3 and 4: dot products, then sign fix and range tests
// depends on sti_pkg
module sti_stage_test (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic valid_s2,
	input  sti_pkg::cvec_t n_s2,
	input  sti_pkg::cvec_t vxd_s2,
	input  sti_pkg::cvec_t wxd_s2,
	input  sti_pkg::dvec_t u_s2,
	input  sti_pkg::dvec_t d_s2,
	input  sti_pkg::dvec_t w0_s2,
	output logic valid_s4,
	output sti_pkg::cause_t cause_s4
);
	logic valid_s3, degen_s3;
	sti_pkg::dot_t den_s3, nt_s3, ns_s3, nr_s3;
	sti_pkg::dot_t den, nt, ns, nr;
	logic signed [sti_pkg::SUM_WIDTH-1:0] sr;
	sti_pkg::cause_t cause;
	sti_pkg::cvec_t wxd_neg;

	always_comb begin
		wxd_neg.x = -wxd_s2.x;
		wxd_neg.y = -wxd_s2.y;
		wxd_neg.z = -wxd_s2.z;
	end

	always_comb begin
		den = den_s3;
		nt = nt_s3;
		ns = ns_s3;
		nr = nr_s3;
		if (den_s3 < 0) begin
			den = -den_s3;
			nt = -nt_s3;
			ns = -ns_s3;
			nr = -nr_s3;
		end
		sr = sti_pkg::SUM_WIDTH'(ns) + sti_pkg::SUM_WIDTH'(nr);
		if (degen_s3)
			cause = sti_pkg::CAUSE_DEGENERATE;
		else if (den_s3 == 0)
			cause = sti_pkg::CAUSE_PARALLEL;
		else if (nt < 0 || nt > den)
			cause = sti_pkg::CAUSE_BEYOND;
		else if (ns < 0 || ns > den || nr < 0 || sr > sti_pkg::SUM_WIDTH'(den))
			cause = sti_pkg::CAUSE_OUTSIDE;
		else
			cause = sti_pkg::CAUSE_HIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// num_t = n.(a-p0) = -n.w0; num_r = u.(w0 x d) = (w0 x d).u
	always_ff @(posedge clk) begin
		if (adv) begin
			degen_s3 <= n_s2 == '0;
			den_s3 <= sti_pkg::vdot(n_s2, d_s2);
			nt_s3 <= -sti_pkg::vdot(n_s2, w0_s2);
			ns_s3 <= sti_pkg::vdot(vxd_s2, w0_s2);
			nr_s3 <= -sti_pkg::vdot(wxd_neg, u_s2);
			cause_s4 <= cause;
		end
	end
endmodule

// ===== design/segment_triangle_intersect.sv =====
// Segment/triangle intersection test, one transfer in per clock while not stalled and one
// result per item. Four register stages (edge vectors, cross products, dot products, range
// tests), the last of which holds the result; the whole pipe holds on stall.
// depends on sti_pkg, sti_stage_cross, sti_stage_test and the assertion header
`include "segment_triangle_intersect_defines.svh"
module segment_triangle_intersect (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [sti_pkg::POINT_WIDTH-1:0] seg_origin,
	input  logic [sti_pkg::POINT_WIDTH-1:0] seg_end,
	input  logic [sti_pkg::POINT_WIDTH-1:0] corner_a,
	input  logic [sti_pkg::POINT_WIDTH-1:0] corner_b,
	input  logic [sti_pkg::POINT_WIDTH-1:0] corner_c,
	output logic out_valid,
	input  logic out_stall,
	output logic hit,
	output logic [2:0] miss_cause
);
	logic adv, valid_s2, valid_s4;
	sti_pkg::cvec_t n_s2, vxd_s2, wxd_s2;
	sti_pkg::dvec_t u_s2, d_s2, w0_s2;
	sti_pkg::cause_t cause_s4;

	// pipe advances whenever the last stage can move on
	assign adv = !(valid_s4 && out_stall);
	assign in_stall = !adv;
	assign out_valid = valid_s4;
	assign hit = cause_s4 == sti_pkg::CAUSE_HIT;
	assign miss_cause = cause_s4;

	sti_stage_cross u_cross (
		.clk, .arst_n, .adv, .in_valid,
		.seg_origin, .seg_end, .corner_a, .corner_b, .corner_c,
		.valid_s2, .n_s2, .vxd_s2, .wxd_s2, .u_s2, .d_s2, .w0_s2
	);

	sti_stage_test u_test (
		.clk, .arst_n, .adv, .valid_s2,
		.n_s2, .vxd_s2, .wxd_s2, .u_s2, .d_s2, .w0_s2,
		.valid_s4, .cause_s4
	);

	`STI_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(miss_cause))
	`STI_ASSERT_IMP(a_hit_code, clk, arst_n, out_valid,
		hit == (miss_cause == sti_pkg::CAUSE_HIT))
	`STI_ASSERT_IMP(a_no_singular, clk, arst_n, out_valid,
		miss_cause != sti_pkg::CAUSE_SINGULAR && miss_cause <= sti_pkg::CAUSE_OUTSIDE)
	`STI_ASSERT_IMP(a_stall_tie, clk, arst_n, in_stall, out_valid && out_stall)
endmodule
